/* design/fsmc_pkg.sv */
// Package: shared constants, codes and pattern tables for the fan speed mode controller.
package fsmc_pkg;

    // Drive level codes
    localparam logic [1:0] DRV_OFF  = 2'd0;
    localparam logic [1:0] DRV_LOW  = 2'd1;
    localparam logic [1:0] DRV_MED  = 2'd2;
    localparam logic [1:0] DRV_HIGH = 2'd3;

    // Mode codes
    localparam logic [2:0] MODE_NATURAL = 3'd1;
    localparam logic [2:0] MODE_SLEEP   = 3'd2;
    localparam logic [2:0] MODE_MANUAL  = 3'd4;

    // Configuration register indexes
    localparam logic CFG_STEP_SECONDS = 1'b0;
    localparam logic CFG_SLEEP_CYCLES = 1'b1;

    // Configuration reset values
    localparam logic [5:0] STEP_SECONDS_RST = 6'd25;
    localparam logic [3:0] SLEEP_CYCLES_RST = 4'd2;

    // Start-up checkpoints (seconds)
    localparam logic [1:0] STARTUP_DRIVE_SEC = 2'd1;
    localparam logic [1:0] STARTUP_END_SEC   = 2'd3;

    // Sleep reduction saturates here
    localparam logic [1:0] SLEEP_DROP_MAX = 2'd3;

    // Positions with table entries
    localparam int TABLE_STEPS = 32;

    typedef logic [31:0] t_mask;

    // Pattern masks, indexed by intensity (1..3)
    localparam t_mask PAT_HIGH [4] = '{
        32'h0000_0000,
        32'h0040_0040,
        32'h0080_8410,
        32'h0848_8441
    };
    localparam t_mask PAT_MED [4] = '{
        32'h0000_0000,
        32'h8810_4404,
        32'h2108_1021,
        32'h0100_1104
    };
    localparam t_mask PAT_LOW [4] = '{
        32'h0000_0000,
        32'h2102_1111,
        32'h8842_0104,
        32'h4012_0010
    };

    // Table lookup; returns hit flag and level for intensity and position
    function automatic logic [2:0] pattern_lookup(input logic [1:0] eff,
                                                  input logic [4:0] pos);
        logic [2:0] res;
        res = {1'b0, DRV_OFF};
        if (PAT_HIGH[eff][pos]) begin
            res = {1'b1, DRV_HIGH};
        end else if (PAT_MED[eff][pos]) begin
            res = {1'b1, DRV_MED};
        end else if (PAT_LOW[eff][pos]) begin
            res = {1'b1, DRV_LOW};
        end
        return res;
    endfunction

endpackage

/* design/fan_speed_mode_controller_core.sv */
// Top level: fan speed mode controller with start-up, natural/sleep patterns and manual speed.
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+----------------------------------------------
//  request  | in        | i_valid / o_stall   | i_second_tick i_power_on i_swing_on
//           |           |                     | i_fan_mode i_speed_sel
//  result   | out       | o_valid / i_stall   | o_high_relay_n o_medium_relay_n
//           |           |                     | o_low_relay_n o_swing_pin_n
//  config   | in        | i_cfg_we            | i_cfg_idx i_cfg_data
//
// A request is held in the input register, then its result is computed combinationally
// from the control state and lands in the result register: one request per cycle
// sustained while the result side does not stall, set by the state update between the
// input and result registers. Synchronous active-low reset clears all control state,
// sets the drive level off, the swing state high and the configuration to its defaults;
// the result register is not reset. A result stall holds the result register and a full
// input register; o_stall rises only when the input register is full and cannot advance.
module fan_speed_mode_controller_core
    import fsmc_pkg::*;
#(
    parameter int PATTERN_STEPS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_second_tick,
    input  logic       i_power_on,
    input  logic       i_swing_on,
    input  logic [2:0] i_fan_mode,
    input  logic [1:0] i_speed_sel,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_high_relay_n,
    output logic       o_medium_relay_n,
    output logic       o_low_relay_n,
    output logic       o_swing_pin_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [5:0] i_cfg_data
);

    localparam int PS_W = $clog2(PATTERN_STEPS);
    localparam logic [PS_W:0] PS_LAST = (PS_W + 1)'(PATTERN_STEPS);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [5:0] r_step_seconds;
    logic [3:0] r_sleep_cycles;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_seconds <= STEP_SECONDS_RST;
            r_sleep_cycles <= SLEEP_CYCLES_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_STEP_SECONDS) begin
                r_step_seconds <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_SLEEP_CYCLES) begin
                r_sleep_cycles <= i_cfg_data[3:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // Handshake: input register feeds the result register
    // ---------------------------------------------------------------
    logic       r_in_vld;
    logic       r_tick, r_pwr, r_swg;
    logic [2:0] r_mode;
    logic [1:0] r_spd;
    logic       r_out_vld;
    logic       out_open;
    logic       fire;

    // result register can take a new value when empty or being drained
    assign out_open = !r_out_vld || !i_stall;
    assign fire     = r_in_vld && out_open;
    assign o_stall  = r_in_vld && !out_open;
    assign o_valid  = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_vld <= i_valid;
            end
            if (out_open) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // capture the request payload whenever the input register is free
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_tick <= i_second_tick;
            r_pwr  <= i_power_on;
            r_swg  <= i_swing_on;
            r_mode <= i_fan_mode;
            r_spd  <= i_speed_sel;
        end
    end

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    logic            r_tick_pending, n_tick_pending;
    logic            r_startup_done, n_startup_done;
    logic [1:0]      r_startup_sec,  n_startup_sec;
    logic            r_power_seen,   n_power_seen;
    logic            r_swing_seen,   n_swing_seen;
    logic [1:0]      r_applied_spd,  n_applied_spd;
    logic [5:0]      r_sec_in_step,  n_sec_in_step;
    logic [PS_W-1:0] r_pat_step,     n_pat_step;
    logic [3:0]      r_pass_cnt,     n_pass_cnt;
    logic [1:0]      r_sleep_drop,   n_sleep_drop;
    logic [1:0]      r_drive,        n_drive;
    logic            r_swing_pin,    n_swing_pin;

    logic [PS_W:0]   pat_step_inc;
    logic [1:0]      eff_old, eff_new;
    logic [6:0]      pos_ext;
    logic [2:0]      lookup;
    logic            is_natural;

    // intensity in effect: speed less sleep drop in sleep mode, floor at low
    function automatic logic [1:0] eff_speed(input logic [2:0] mode,
                                             input logic [1:0] spd,
                                             input logic [1:0] drop);
        logic [2:0] drop_p1;
        logic [1:0] res;
        drop_p1 = {1'b0, drop} + 3'd1;
        if (spd == DRV_OFF) begin
            res = DRV_OFF;
        end else if (mode != MODE_SLEEP) begin
            res = spd;
        end else if ({1'b0, spd} > drop_p1) begin
            res = spd - drop;
        end else begin
            res = DRV_LOW;
        end
        return res;
    endfunction

    assign is_natural   = (r_mode == MODE_NATURAL) || (r_mode == MODE_SLEEP);
    assign pat_step_inc = {1'b0, r_pat_step} + (PS_W + 1)'(1);
    assign eff_old      = eff_speed(r_mode, r_spd, r_sleep_drop);

    always_comb begin
        n_tick_pending = r_tick_pending | r_tick;
        n_startup_done = r_startup_done;
        n_startup_sec  = r_startup_sec;
        n_power_seen   = r_power_seen;
        n_swing_seen   = r_swing_seen;
        n_applied_spd  = r_applied_spd;
        n_sec_in_step  = r_sec_in_step;
        n_pat_step     = r_pat_step;
        n_pass_cnt     = r_pass_cnt;
        n_sleep_drop   = r_sleep_drop;
        n_drive        = r_drive;
        n_swing_pin    = r_swing_pin;
        eff_new        = eff_old;
        pos_ext        = '0;
        lookup         = '0;

        if (r_pwr) begin
            n_power_seen = 1'b1;
            if (!r_startup_done) begin
                // start-up: medium at second 1, finish at second 3
                if (n_tick_pending) begin
                    n_tick_pending = 1'b0;
                    n_startup_sec  = r_startup_sec + 2'd1;
                    if (n_startup_sec == STARTUP_DRIVE_SEC) begin
                        n_drive       = DRV_MED;
                        n_applied_spd = DRV_MED;
                    end else if (n_startup_sec == STARTUP_END_SEC) begin
                        n_startup_done = 1'b1;
                        n_startup_sec  = '0;
                    end
                end
            end else if (is_natural) begin
                // natural step: consume the tick, advance the pattern on match
                if (n_tick_pending) begin
                    n_tick_pending = 1'b0;
                    n_sec_in_step  = r_sec_in_step + 6'd1;
                    if (n_sec_in_step == r_step_seconds) begin
                        n_sec_in_step = '0;
                        n_pat_step    = pat_step_inc[PS_W-1:0];
                        if (pat_step_inc >= PS_LAST) begin
                            n_pat_step = '0;
                            n_pass_cnt = r_pass_cnt + 4'd1;
                            if (n_pass_cnt >= r_sleep_cycles) begin
                                n_pass_cnt = '0;
                                if (r_mode == MODE_SLEEP && eff_old > DRV_LOW &&
                                    r_sleep_drop < SLEEP_DROP_MAX) begin
                                    n_sleep_drop = r_sleep_drop + 2'd1;
                                end
                            end
                        end
                        eff_new = eff_speed(r_mode, r_spd, n_sleep_drop);
                        pos_ext = 7'(n_pat_step);
                        lookup  = pattern_lookup(eff_new, pos_ext[4:0]);
                        // no table: speed none or position past the table
                        if (eff_new != DRV_OFF && pos_ext < 7'(TABLE_STEPS) &&
                            lookup[2]) begin
                            n_drive = lookup[1:0];
                        end
                    end
                end
            end else if (r_mode == MODE_MANUAL) begin
                // manual: apply only a changed speed request
                if (r_applied_spd != r_spd) begin
                    n_applied_spd = r_spd;
                    n_drive       = r_spd;
                end
            end
            if (r_swing_seen != r_swg) begin
                n_swing_seen = r_swg;
                n_swing_pin  = !r_swg;
            end
        end else if (r_power_seen) begin
            // first item after power drops: release all relays
            n_power_seen = 1'b0;
            n_drive      = DRV_OFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_pending <= 1'b0;
            r_startup_done <= 1'b0;
            r_startup_sec  <= '0;
            r_power_seen   <= 1'b0;
            r_swing_seen   <= 1'b0;
            r_applied_spd  <= '0;
            r_sec_in_step  <= '0;
            r_pat_step     <= '0;
            r_pass_cnt     <= '0;
            r_sleep_drop   <= '0;
            r_drive        <= DRV_OFF;
            r_swing_pin    <= 1'b1;
        end else if (fire) begin
            r_tick_pending <= n_tick_pending;
            r_startup_done <= n_startup_done;
            r_startup_sec  <= n_startup_sec;
            r_power_seen   <= n_power_seen;
            r_swing_seen   <= n_swing_seen;
            r_applied_spd  <= n_applied_spd;
            r_sec_in_step  <= n_sec_in_step;
            r_pat_step     <= n_pat_step;
            r_pass_cnt     <= n_pass_cnt;
            r_sleep_drop   <= n_sleep_drop;
            r_drive        <= n_drive;
            r_swing_pin    <= n_swing_pin;
        end
    end

    // ---------------------------------------------------------------
    // Result register: pins decoded from the updated drive level
    // ---------------------------------------------------------------
    logic r_high_n, r_med_n, r_low_n, r_swing_n;

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_high_n  <= (n_drive != DRV_HIGH);
            r_med_n   <= (n_drive != DRV_MED);
            r_low_n   <= (n_drive != DRV_LOW);
            r_swing_n <= n_swing_pin;
        end
    end

    assign o_high_relay_n   = r_high_n;
    assign o_medium_relay_n = r_med_n;
    assign o_low_relay_n    = r_low_n;
    assign o_swing_pin_n    = r_swing_n;

endmodule

/* test/fsmc_checker.sv */
// Checker: predicts the relay and swing pins for every accepted request and compares results.
module fsmc_checker
    import fsmc_pkg::*;
#(
    parameter int PATTERN_STEPS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_stall,
    input  logic       i_second_tick,
    input  logic       i_power_on,
    input  logic       i_swing_on,
    input  logic [2:0] i_fan_mode,
    input  logic [1:0] i_speed_sel,
    input  logic       i_res_valid,
    input  logic       i_res_stall,
    input  logic       i_high_relay_n,
    input  logic       i_medium_relay_n,
    input  logic       i_low_relay_n,
    input  logic       i_swing_pin_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [5:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic high_n;
        logic med_n;
        logic low_n;
        logic swing_n;
    } t_relay_word;

    // Pattern positions per intensity 1..3, one mask per relay
    localparam logic [31:0] HIGH_POS [4] = '{
        32'h0000_0000,      // none
        32'h0040_0040,      // 6 22
        32'h0080_8410,      // 4 10 15 23
        32'h0848_8441       // 0 6 10 15 19 22 27
    };
    localparam logic [31:0] MED_POS [4] = '{
        32'h0000_0000,
        32'h8810_4404,      // 2 10 14 20 27 31
        32'h2108_1021,      // 0 5 12 19 24 29
        32'h0100_1104       // 2 8 12 24
    };
    localparam logic [31:0] LOW_POS [4] = '{
        32'h0000_0000,
        32'h2102_1111,      // 0 4 8 12 17 24 29
        32'h8842_0104,      // 2 8 17 22 27 31
        32'h4012_0010       // 4 17 20 30
    };

    logic [5:0] cfg_step_secs;
    logic [3:0] cfg_sleep_passes;

    logic       sec_pending;
    logic       boot_done;
    logic [1:0] boot_secs;
    logic       pwr_latched;
    logic       swing_latched;
    logic [1:0] speed_applied;
    logic [5:0] secs_in_step;
    int         pat_pos;
    logic [3:0] pass_cnt;
    logic [1:0] drop_lvl;
    logic [1:0] level;
    logic       swing_level;

    t_relay_word expected_relays [$];
    int fail_cnt    = 0;
    int pending_cnt = 0;
    int res_idx     = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;

    task automatic clear_state();
        cfg_step_secs    = STEP_SECONDS_RST;
        cfg_sleep_passes = SLEEP_CYCLES_RST;
        sec_pending   = 1'b0;
        boot_done     = 1'b0;
        boot_secs     = 2'd0;
        pwr_latched   = 1'b0;
        swing_latched = 1'b0;
        speed_applied = 2'd0;
        secs_in_step  = 6'd0;
        pat_pos       = 0;
        pass_cnt      = 4'd0;
        drop_lvl      = 2'd0;
        level         = DRV_OFF;
        swing_level   = 1'b1;
    endtask

    // Sleep mode lowers the requested speed by the accumulated drop, floor 1
    function automatic logic [1:0] intensity(input logic [2:0] mode, input logic [1:0] spd);
        if (spd == 2'd0) return 2'd0;
        if (mode != MODE_SLEEP) return spd;
        if (int'(spd) > int'(drop_lvl) + 1) return spd - drop_lvl;
        return 2'd1;
    endfunction

    task automatic step_natural_pattern(input logic [2:0] mode, input logic [1:0] spd);
        logic [1:0] eff;
        if (!sec_pending) return;
        sec_pending  = 1'b0;
        secs_in_step = secs_in_step + 6'd1;
        if (secs_in_step != cfg_step_secs) return;
        secs_in_step = 6'd0;
        pat_pos++;
        if (pat_pos >= PATTERN_STEPS) begin
            pat_pos  = 0;
            pass_cnt = pass_cnt + 4'd1;
            if (pass_cnt >= cfg_sleep_passes) begin
                pass_cnt = 4'd0;
                if (mode == MODE_SLEEP && intensity(mode, spd) > 2'd1
                        && drop_lvl < SLEEP_DROP_MAX) begin
                    drop_lvl = drop_lvl + 2'd1;
                end
            end
        end
        eff = intensity(mode, spd);
        // positions without an entry keep the relays as they are
        if (eff == 2'd0 || pat_pos >= 32) return;
        if (HIGH_POS[eff][pat_pos]) begin
            level = DRV_HIGH;
        end else if (MED_POS[eff][pat_pos]) begin
            level = DRV_MED;
        end else if (LOW_POS[eff][pat_pos]) begin
            level = DRV_LOW;
        end
    endtask

    task automatic compute_relays(input logic tick, pwr, swg, input logic [2:0] mode,
                                  input logic [1:0] spd, output t_relay_word word);
        if (tick) sec_pending = 1'b1;
        if (pwr) begin
            pwr_latched = 1'b1;
            if (!boot_done) begin
                if (sec_pending) begin
                    sec_pending = 1'b0;
                    boot_secs   = boot_secs + 2'd1;
                    if (boot_secs == STARTUP_DRIVE_SEC) begin
                        level         = DRV_MED;
                        speed_applied = DRV_MED;
                    end else if (boot_secs == STARTUP_END_SEC) begin
                        boot_done = 1'b1;
                        boot_secs = 2'd0;
                    end
                end
            end else if (mode == MODE_NATURAL || mode == MODE_SLEEP) begin
                step_natural_pattern(mode, spd);
            end else if (mode == MODE_MANUAL) begin
                if (speed_applied != spd) begin
                    speed_applied = spd;
                    level         = spd;
                end
            end
            if (swing_latched != swg) begin
                swing_latched = swg;
                swing_level   = ~swg;
            end
        end else if (pwr_latched) begin
            pwr_latched = 1'b0;
            level       = DRV_OFF;
        end
        word.high_n  = (level != DRV_HIGH);
        word.med_n   = (level != DRV_MED);
        word.low_n   = (level != DRV_LOW);
        word.swing_n = swing_level;
    endtask

    task automatic report_failure(input string msg);
        $display("[%0t] FAIL result %0d: %s", $realtime, res_idx, msg);
        fail_cnt++;
    endtask

    task automatic check_pin(input string pin, input logic got, input logic want);
        if (got !== want) begin
            report_failure($sformatf("%s got %b expected %b", pin, got, want));
        end
    endtask

    always @(posedge i_clk) begin : observe
        t_relay_word got;
        t_relay_word want;
        t_relay_word predicted;
        if (!i_rst_n) begin
            clear_state();
            expected_relays.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_STEP_SECONDS) begin
                    cfg_step_secs = i_cfg_data;
                end else begin
                    cfg_sleep_passes = i_cfg_data[3:0];
                end
            end
            // retire the oldest expectation before queueing this edge's request
            if (i_res_valid && !i_res_stall) begin
                got = {i_high_relay_n, i_medium_relay_n, i_low_relay_n, i_swing_pin_n};
                if (expected_relays.size() == 0) begin
                    report_failure("result with no request outstanding");
                end else begin
                    want = expected_relays.pop_front();
                    check_pin("high_relay_n", got.high_n, want.high_n);
                    check_pin("medium_relay_n", got.med_n, want.med_n);
                    check_pin("low_relay_n", got.low_n, want.low_n);
                    check_pin("swing_pin_n", got.swing_n, want.swing_n);
                end
                res_idx++;
            end
            if (i_req_valid && !i_req_stall) begin
                compute_relays(i_second_tick, i_power_on, i_swing_on, i_fan_mode,
                               i_speed_sel, predicted);
                expected_relays.push_back(predicted);
            end
        end
        pending_cnt <= expected_relays.size();
    end

endmodule

/* test/tb.sv */
// Testbench top: drives requests, results back-pressure and configuration, and gives the verdict.
module tb
    import fsmc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAT_STEPS      = 32;
    localparam int MAX_GAP        = 18;
    localparam int HOLD_CYCLES    = 250;   // long result-side hold-off to fill the block
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES   = 8;     // settling margin after the checker queue empties

    // mode 3 has no code in the package
    localparam logic [2:0] MODE_HOLD = 3'd3;

    // random request mixes
    localparam int MIX_ANY     = 0;
    localparam int MIX_SLEEP   = 1;
    localparam int MIX_NATURAL = 2;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    logic       req_tick = 1'b0;
    logic       req_power = 1'b0;
    logic       req_swing = 1'b0;
    logic [2:0] req_mode = 3'd0;
    logic [1:0] req_speed = 2'd0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic       high_n, med_n, low_n, swing_n;
    logic       cfg_we = 1'b0;
    logic       cfg_idx = 1'b0;
    logic [5:0] cfg_data = 6'd0;

    int  fail_count;
    int  pending;
    bit  src_burst = 1'b0;
    bit  sink_burst = 1'b0;
    bit  hold_off = 1'b0;
    logic [1:0] sticky_speed = 2'd3;

    fan_speed_mode_controller_core #(
        .PATTERN_STEPS(PAT_STEPS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (req_valid),
        .o_stall         (req_stall),
        .i_second_tick   (req_tick),
        .i_power_on      (req_power),
        .i_swing_on      (req_swing),
        .i_fan_mode      (req_mode),
        .i_speed_sel     (req_speed),
        .o_valid         (res_valid),
        .i_stall         (res_stall),
        .o_high_relay_n  (high_n),
        .o_medium_relay_n(med_n),
        .o_low_relay_n   (low_n),
        .o_swing_pin_n   (swing_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    fsmc_checker #(
        .PATTERN_STEPS(PAT_STEPS)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (req_valid),
        .i_req_stall     (req_stall),
        .i_second_tick   (req_tick),
        .i_power_on      (req_power),
        .i_swing_on      (req_swing),
        .i_fan_mode      (req_mode),
        .i_speed_sel     (req_speed),
        .i_res_valid     (res_valid),
        .i_res_stall     (res_stall),
        .i_high_relay_n  (high_n),
        .i_medium_relay_n(med_n),
        .i_low_relay_n   (low_n),
        .i_swing_pin_n   (swing_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Offer one request after a random gap and hold it until accepted. Valid is only
    // lowered when a gap follows, so back-to-back requests never glitch it.
    task automatic push_request(input logic tick, pwr, swg, input logic [2:0] mode,
                                input logic [1:0] spd);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_tick  <= tick;
        req_power <= pwr;
        req_swing <= swg;
        req_mode  <= mode;
        req_speed <= spd;
        do @(posedge clk); while (!(req_valid && !req_stall));
    endtask

    // Mostly powered-on natural, sleep and manual traffic with ticks, so the pattern
    // and the sleep drop actually advance; the rest is unconstrained noise.
    task automatic push_random(input int mix);
        logic       tick, pwr, swg;
        logic [2:0] mode;
        logic [1:0] spd;
        int         pick;
        pick = $urandom_range(0, 9);
        if ($urandom_range(0, 99) < 85) begin
            pwr  = 1'b1;
            tick = ($urandom_range(0, 3) != 0);
            swg  = 1'($urandom_range(0, 1));
            case (mix)
                MIX_SLEEP: begin
                    mode = (pick < 7) ? MODE_SLEEP : (pick < 8) ? MODE_NATURAL :
                           (pick < 9) ? MODE_MANUAL : MODE_HOLD;
                end
                MIX_NATURAL: begin
                    mode = (pick < 7) ? MODE_NATURAL : (pick < 8) ? MODE_SLEEP :
                           (pick < 9) ? MODE_MANUAL : MODE_HOLD;
                end
                default: begin
                    mode = (pick < 3) ? MODE_NATURAL : (pick < 6) ? MODE_SLEEP :
                           (pick < 8) ? MODE_MANUAL : MODE_HOLD;
                end
            endcase
            // keep the speed mostly steady so a pattern runs at one intensity
            if ($urandom_range(0, 15) == 0) sticky_speed = 2'($urandom_range(0, 3));
            spd = sticky_speed;
        end else begin
            {tick, pwr, swg, mode, spd} = 8'($urandom_range(0, 255));
        end
        push_request(tick, pwr, swg, mode, spd);
    endtask

    task automatic run_phase(input int count, input int mix);
        for (int k = 0; k < count; k++) begin
            // redraw the no-idle stretches now and then
            if (k > 0 && k % 40 == 0) begin
                src_burst  = ($urandom_range(0, 3) == 0);
                sink_burst = ($urandom_range(0, 3) == 0);
            end
            push_random(mix);
        end
    endtask

    // Drop valid, drain every outstanding result, then write both registers.
    task automatic reconfigure(input logic [5:0] step_secs, input logic [5:0] sleep_word);
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_STEP_SECONDS;
        cfg_data <= step_secs;
        @(posedge clk);
        cfg_idx  <= CFG_SLEEP_CYCLES;
        cfg_data <= sleep_word;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Result side: random stall before each result, one long hold-off on request.
    initial begin : result_sink
        int n;
        forever begin
            if (hold_off) begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end else begin
                n = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
                if (n > 0) begin
                    res_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!(res_valid && !res_stall));
        end
    end

    // Watchdog: give up after a long run of cycles with no handshake on either side.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("fan_speed_mode_controller_core regression: fail");
        $finish;
    end

    initial begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: power off before anything, a tick left pending while off,
        // the one-time start-up, manual speeds including release, hold keeping a
        // tick pending, natural and sleep steps, power off twice, idle modes, extremes.
        push_request(1'b0, 1'b0, 1'b0, 3'd0, 2'd0);
        push_request(1'b1, 1'b0, 1'b1, MODE_NATURAL, 2'd3);
        push_request(1'b0, 1'b1, 1'b1, 3'd7, 2'd3);
        push_request(1'b1, 1'b1, 1'b0, MODE_HOLD, 2'd1);
        push_request(1'b1, 1'b1, 1'b1, MODE_MANUAL, 2'd3);
        push_request(1'b1, 1'b1, 1'b1, MODE_NATURAL, 2'd2);
        push_request(1'b0, 1'b1, 1'b0, MODE_MANUAL, 2'd3);
        push_request(1'b0, 1'b1, 1'b0, MODE_MANUAL, 2'd0);
        push_request(1'b0, 1'b1, 1'b1, MODE_MANUAL, 2'd1);
        push_request(1'b0, 1'b1, 1'b1, MODE_MANUAL, 2'd2);
        push_request(1'b1, 1'b1, 1'b1, MODE_HOLD, 2'd3);
        push_request(1'b0, 1'b1, 1'b1, MODE_NATURAL, 2'd2);
        push_request(1'b1, 1'b1, 1'b0, MODE_SLEEP, 2'd3);
        push_request(1'b1, 1'b1, 1'b0, MODE_SLEEP, 2'd0);
        push_request(1'b0, 1'b0, 1'b1, MODE_MANUAL, 2'd3);
        push_request(1'b1, 1'b0, 1'b0, MODE_SLEEP, 2'd1);
        push_request(1'b1, 1'b1, 1'b1, 3'd5, 2'd2);
        push_request(1'b1, 1'b1, 1'b0, 3'd6, 2'd1);
        push_request(1'b1, 1'b1, 1'b1, 3'd0, 2'd3);
        push_request(1'b1, 1'b1, 1'b1, 3'd7, 2'd3);
        push_request(1'b0, 1'b0, 1'b0, 3'd0, 2'd0);

        // Fastest pattern, a sleep drop every pass; start under a long result hold-off
        // with the sender offering back to back so the block fills and stalls.
        reconfigure(6'd1, {2'b11, 4'd1});
        src_burst = 1'b1;
        hold_off  = 1'b1;
        sticky_speed = 2'd3;
        run_phase(150, MIX_SLEEP);
        src_burst = 1'b0;

        // Slowest legal settings
        reconfigure(6'd63, {2'b00, 4'd15});
        run_phase(80, MIX_ANY);

        // Zero step count wraps the second counter; zero passes reduce every pass
        reconfigure(6'd0, {2'b10, 4'd0});
        run_phase(80, MIX_NATURAL);

        reconfigure(6'd2, {2'b01, 4'd3});
        run_phase(100, MIX_ANY);

        reconfigure(6'($urandom_range(1, 4)), 6'($urandom_range(0, 63)));
        run_phase(100, MIX_SLEEP);

        // Drain and let the pipeline settle before the verdict
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("fan_speed_mode_controller_core regression: pass");
        end else begin
            $display("fan_speed_mode_controller_core regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
design/fsmc_pkg.sv
design/fan_speed_mode_controller_core.sv
test/fsmc_checker.sv
test/tb.sv
